// ----- design/hsv_hue_window_grade_defines.svh -----
// Assertion macros used by the port-level checker of the hue window grade block.
`ifndef HSV_HUE_WINDOW_GRADE_DEFINES_SVH
`define HSV_HUE_WINDOW_GRADE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HHWG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked also during reset.
`define HHWG_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/hhwg_pkg.sv -----
// Package with register indexes and shared arithmetic for the hue window grade block.
`default_nettype none
package hhwg_pkg;

    localparam int unsigned AddrWidth = 5;

    typedef enum logic [2:0] {
        REG_HUE_LOW    = 3'd0,
        REG_HUE_HIGH   = 3'd1,
        REG_HUE_SHIFT  = 3'd2,
        REG_FORCE_EN   = 3'd3,
        REG_FORCED_HUE = 3'd4,
        REG_SAT_EN     = 3'd5
    } t_reg_idx;

    // Exact floor(y / 255) for y below 255 * 2^16, built from shifts and small adds.
    // y = 255*q0 + r0 with q0 = y >> 8, r0 = (y & 255) + q0; repeated once more.
    function automatic logic [15:0] div255(input logic [23:0] y);
        logic [15:0] q0;
        logic [16:0] r0;
        logic [8:0]  q1;
        logic [9:0]  r1;
        logic [1:0]  f;
        q0 = y[23:8];
        r0 = {9'd0, y[7:0]} + {1'b0, q0};
        q1 = r0[16:8];
        r1 = {2'd0, r0[7:0]} + {1'b0, q1};
        if (r1 >= 10'd510) begin
            f = 2'd2;
        end else if (r1 >= 10'd255) begin
            f = 2'd1;
        end else begin
            f = 2'd0;
        end
        return q0 + {7'd0, q1} + {14'd0, f};
    endfunction

endpackage
`default_nettype wire

// ----- design/hsv_hue_window_grade.sv -----
// Top level of the hue window grade block: RGB to HSV, hue and saturation grade, back to RGB.
//
// Channel   Dir  Handshake              Payload
// s         in   i_s_tvalid/o_s_tready  i_s_tdata: red, green, blue
// m         out  o_m_tvalid/i_m_tready  o_m_tdata: red, green, blue
// apb       in   psel/penable, pready   six grade registers at 4*index
//
// One pixel enters per clock while the pipeline advances. There is one setup
// stage, eight restoring divider stages (one quotient bit each) and six stages
// for grading and the back conversion. The whole pipeline advances when the output
// register is empty or being read, so a stall holds every stage in place.
// Reset is synchronous, loads the configuration registers with their defaults and clears all stage valid bits.
`default_nettype none
module hsv_hue_window_grade (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // [7:0] red_in, [15:8] green_in, [23:16] blue_in
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // [7:0] red_out, [15:8] green_out, [23:16] blue_out
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [hhwg_pkg::AddrWidth-1:0] i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic [31:0]      o_prdata,
    output logic             o_pready
);

    localparam int unsigned NStages = 15;

    // Configuration registers.
    logic [7:0] r_hue_low, r_hue_high, r_hue_shift, r_forced_hue;
    logic       r_force_en, r_sat_en;
    logic [2:0] w_idx;
    logic       w_wr;

    assign o_pready = 1'b1;
    assign w_idx    = i_paddr[4:2];
    assign w_wr     = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_low    <= 8'd128;
            r_hue_high   <= 8'd153;
            r_hue_shift  <= 8'd55;
            r_force_en   <= 1'b0;
            r_forced_hue <= 8'd43;
            r_sat_en     <= 1'b0;
        end else if (w_wr) begin
            unique case (w_idx)
                hhwg_pkg::REG_HUE_LOW:    r_hue_low    <= i_pwdata[7:0];
                hhwg_pkg::REG_HUE_HIGH:   r_hue_high   <= i_pwdata[7:0];
                hhwg_pkg::REG_HUE_SHIFT:  r_hue_shift  <= i_pwdata[7:0];
                hhwg_pkg::REG_FORCE_EN:   r_force_en   <= i_pwdata[0];
                hhwg_pkg::REG_FORCED_HUE: r_forced_hue <= i_pwdata[7:0];
                hhwg_pkg::REG_SAT_EN:     r_sat_en     <= i_pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            hhwg_pkg::REG_HUE_LOW:    o_prdata = {24'd0, r_hue_low};
            hhwg_pkg::REG_HUE_HIGH:   o_prdata = {24'd0, r_hue_high};
            hhwg_pkg::REG_HUE_SHIFT:  o_prdata = {24'd0, r_hue_shift};
            hhwg_pkg::REG_FORCE_EN:   o_prdata = {31'd0, r_force_en};
            hhwg_pkg::REG_FORCED_HUE: o_prdata = {24'd0, r_forced_hue};
            hhwg_pkg::REG_SAT_EN:     o_prdata = {31'd0, r_sat_en};
            default:                  o_prdata = 32'd0;
        endcase
    end

    // Pipeline control.
    logic [NStages-1:0] r_vld;
    logic               w_adv;

    assign w_adv      = !r_vld[NStages-1] || i_m_tready;
    assign o_s_tready = w_adv;
    assign o_m_tvalid = r_vld[NStages-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NStages-2:0], i_s_tvalid};
        end
    end

    // Setup stage: max, min, hue numerator and divider operands.
    logic [7:0]  w_r, w_g, w_b, w_mx, w_mn, w_d;
    logic [10:0] w_n;

    assign w_r = i_s_tdata[7:0];
    assign w_g = i_s_tdata[15:8];
    assign w_b = i_s_tdata[23:16];

    always_comb begin
        w_mx = w_r;
        w_mn = w_r;
        if (w_g > w_mx) w_mx = w_g;
        if (w_g < w_mn) w_mn = w_g;
        if (w_b > w_mx) w_mx = w_b;
        if (w_b < w_mn) w_mn = w_b;
        w_d = w_mx - w_mn;
        // Ties for the maximum go to red, then green.
        if (w_mx == w_r) begin
            if (w_g >= w_b) begin
                w_n = {3'd0, w_g} - {3'd0, w_b};
            end else begin
                w_n = 11'd6 * {3'd0, w_d} - ({3'd0, w_b} - {3'd0, w_g});
            end
        end else if (w_mx == w_g) begin
            w_n = {2'd0, w_d, 1'b0} + {3'd0, w_b} - {3'd0, w_r};
        end else begin
            w_n = {1'b0, w_d, 2'd0} + {3'd0, w_r} - {3'd0, w_g};
        end
    end

    // Setup registers 0 and divider stages 1..8: saturation d*255/mx and hue n*256/(6d).
    logic [15:0] r_srem [0:8];
    logic [7:0]  r_sq   [0:8];
    logic [18:0] r_hrem [0:8];
    logic [7:0]  r_hq   [0:8];
    logic [10:0] r_hdiv [0:8];
    logic [7:0]  r_mx   [0:8];
    logic        r_dz   [0:8];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_srem[0] <= {8'd0, w_d} * 16'd255;
            r_sq[0]   <= 8'd0;
            r_hrem[0] <= {w_n, 8'd0};
            r_hq[0]   <= 8'd0;
            r_hdiv[0] <= 11'd6 * {3'd0, w_d};
            r_mx[0]   <= w_mx;
            r_dz[0]   <= (w_d == 8'd0);
            for (int k = 1; k <= 8; k++) begin
                if (r_srem[k-1] >= ({8'd0, r_mx[k-1]} << (8 - k))) begin
                    r_srem[k] <= r_srem[k-1] - ({8'd0, r_mx[k-1]} << (8 - k));
                    r_sq[k]   <= r_sq[k-1] | (8'd1 << (8 - k));
                end else begin
                    r_srem[k] <= r_srem[k-1];
                    r_sq[k]   <= r_sq[k-1];
                end
                if (r_hrem[k-1] >= ({8'd0, r_hdiv[k-1]} << (8 - k))) begin
                    r_hrem[k] <= r_hrem[k-1] - ({8'd0, r_hdiv[k-1]} << (8 - k));
                    r_hq[k]   <= r_hq[k-1] | (8'd1 << (8 - k));
                end else begin
                    r_hrem[k] <= r_hrem[k-1];
                    r_hq[k]   <= r_hq[k-1];
                end
                r_hdiv[k] <= r_hdiv[k-1];
                r_mx[k]   <= r_mx[k-1];
                r_dz[k]   <= r_dz[k-1];
            end
        end
    end

    // Stage A: hue grade and saturation curve square.
    logic [7:0]  w_h0, w_s0, w_ha, w_t;
    logic [7:0]  r_a_h, r_a_s, r_a_v;
    logic [15:0] r_a_tt;

    always_comb begin
        // A grey pixel has hue zero; a black one has saturation zero.
        w_h0 = r_dz[8] ? 8'd0 : r_hq[8];
        w_s0 = (r_mx[8] == 8'd0) ? 8'd0 : r_sq[8];
        if (r_force_en) begin
            w_ha = r_forced_hue;
        end else if (r_hue_low <= w_h0 && w_h0 <= r_hue_high) begin
            w_ha = w_h0 - r_hue_shift;
        end else begin
            w_ha = w_h0;
        end
        w_t = 8'd255 - w_s0;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_h  <= w_ha;
            r_a_s  <= w_s0;
            r_a_v  <= r_mx[8];
            r_a_tt <= {8'd0, w_t} * {8'd0, w_t};
        end
    end

    // Stage B: finish saturation, split hue into sector and remainder.
    logic [15:0] w_ttq, w_secq;
    logic [10:0] w_q6;
    logic [2:0]  w_sec;
    logic [7:0]  r_b_s, r_b_v, r_b_rem;
    logic [2:0]  r_b_sec;

    assign w_ttq  = hhwg_pkg::div255({8'd0, r_a_tt});
    assign w_q6   = {3'd0, r_a_h} * 11'd6;
    assign w_secq = hhwg_pkg::div255({13'd0, w_q6});
    assign w_sec  = w_secq[2:0];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_s   <= r_sat_en ? (8'd255 - w_ttq[7:0]) : r_a_s;
            r_b_v   <= r_a_v;
            r_b_sec <= w_sec;
            r_b_rem <= 8'(w_q6 - {3'd0, w_sec} * 11'd255);
        end
    end

    // Stage C: saturation products.
    logic [15:0] r_c_p1, r_c_p2, r_c_an;
    logic [7:0]  r_c_v;
    logic [2:0]  r_c_sec;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_p1  <= {8'd0, r_b_rem} * {8'd0, r_b_s};
            r_c_p2  <= {8'd0, 8'd255 - r_b_rem} * {8'd0, r_b_s};
            r_c_an  <= {8'd0, r_b_v} * {8'd0, 8'd255 - r_b_s};
            r_c_v   <= r_b_v;
            r_c_sec <= r_b_sec;
        end
    end

    // Stage D: value products for the two ramp channels, flat channel done.
    logic [23:0] r_d_yb, r_d_yc;
    logic [7:0]  r_d_a, r_d_v;
    logic [2:0]  r_d_sec;
    logic [15:0] w_aq;

    assign w_aq = hhwg_pkg::div255({8'd0, r_c_an});

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d_yb  <= {16'd0, r_c_v} * {8'd0, 16'd65025 - r_c_p1};
            r_d_yc  <= {16'd0, r_c_v} * {8'd0, 16'd65025 - r_c_p2};
            r_d_a   <= w_aq[7:0];
            r_d_v   <= r_c_v;
            r_d_sec <= r_c_sec;
        end
    end

    // Stage E: first division by 255 of the ramp channels.
    logic [15:0] r_e_qb, r_e_qc;
    logic [7:0]  r_e_a, r_e_v;
    logic [2:0]  r_e_sec;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e_qb  <= hhwg_pkg::div255(r_d_yb);
            r_e_qc  <= hhwg_pkg::div255(r_d_yc);
            r_e_a   <= r_d_a;
            r_e_v   <= r_d_v;
            r_e_sec <= r_d_sec;
        end
    end

    // Output stage: second division by 255 and sector select.
    logic [15:0] w_bq, w_cq;
    logic [7:0]  w_ob, w_oc;
    logic [23:0] n_out;
    logic [23:0] r_out;

    assign w_bq = hhwg_pkg::div255({8'd0, r_e_qb});
    assign w_cq = hhwg_pkg::div255({8'd0, r_e_qc});
    assign w_ob = w_bq[7:0];
    assign w_oc = w_cq[7:0];

    always_comb begin
        case (r_e_sec)
            3'd0:    n_out = {r_e_a, w_oc, r_e_v};
            3'd1:    n_out = {r_e_a, r_e_v, w_ob};
            3'd2:    n_out = {w_oc, r_e_v, r_e_a};
            3'd3:    n_out = {r_e_v, w_ob, r_e_a};
            3'd4:    n_out = {r_e_v, r_e_a, w_oc};
            // Sector five, and hue 255 which lands in sector six.
            default: n_out = {w_ob, r_e_a, r_e_v};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_m_tdata = r_out;

endmodule
`default_nettype wire

// ----- design/hhwg_checker.sv -----
// Port-level checker for the hue window grade block, bound to its top level.
`default_nettype none
`include "hsv_hue_window_grade_defines.svh"
module hhwg_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [23:0] o_m_tdata,
    input wire logic        o_pready
);

    // A result waiting on a stalled sink keeps its value.
    `HHWG_ASSERT_NOW(a_out_hold, i_clk, i_rst_n, $past(o_m_tvalid && !i_m_tready) && $past(i_rst_n), o_m_tvalid && $stable(o_m_tdata), "stalled transaction changed")
    // Reset empties the pipeline.
    `HHWG_ASSERT_NEXT(a_reset_empty, i_clk, !i_rst_n, !o_m_tvalid, "valid output after reset")
    // With no result held, the block always takes input.
    `HHWG_ASSERT_NOW(a_ready_free, i_clk, i_rst_n, !o_m_tvalid || i_m_tready, o_s_tready, "input blocked without backpressure")
    // The configuration port never waits.
    `HHWG_ASSERT_NOW(a_pready, i_clk, i_rst_n, 1'b1, o_pready, "pready low")

endmodule

bind hsv_hue_window_grade hhwg_checker u_hhwg_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_pready   (o_pready)
);
`default_nettype wire
